/* design/clcd_pkg.sv */
// Shared types and constants for the character LCD init and string writer.
`default_nettype none

package clcd_pkg;

    // Controller states, one-hot.
    typedef enum logic [11:0] {
        ST_INIT1    = 12'b0000_0000_0001,
        ST_INIT2    = 12'b0000_0000_0010,
        ST_INIT3    = 12'b0000_0000_0100,
        ST_INIT4    = 12'b0000_0000_1000,
        ST_INIT5    = 12'b0000_0001_0000,
        ST_INIT6    = 12'b0000_0010_0000,
        ST_WAIT_GO  = 12'b0000_0100_0000,
        ST_CLEAR    = 12'b0000_1000_0000,
        ST_CURSOR   = 12'b0001_0000_0000,
        ST_CHAR     = 12'b0010_0000_0000,
        ST_WAIT_GO0 = 12'b0100_0000_0000,
        ST_POWERUP  = 12'b1000_0000_0000
    } state_t;

    // Item kinds carried on the input tuser bit.
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_POWER_UP_WAIT = 2'd0;
    localparam logic [1:0] REG_LAST_CHAR     = 2'd1;

    // Configuration reset values.
    localparam logic [7:0] POWER_UP_WAIT_RST = 8'd10;
    localparam logic [4:0] LAST_CHAR_RST     = 5'd16;

    // LCD command bytes.
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_LINE1_BASE   = 8'h80;
    localparam logic [7:0] CMD_LINE2_BASE   = 8'hBF;

    // Characters on the first display line.
    localparam logic [7:0] LINE_LEN = 8'd16;

endpackage

`default_nettype wire

/* design/char_lcd_init_and_string_writer_unit.sv */
// Top level of the character LCD init and string writer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  s       | in        | s_tvalid / s_tready  | tuser: operation; tdata: go, index, char
//  m       | out       | m_tvalid / m_tready  | tdata: data, rs, enable, pulsed, ready
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// Each tick item makes at most one state transition plus a pin update between
// the input handshake and the result register. A new item is taken each cycle
// while the result register is empty or being drained in the same cycle.
// Reset puts the controller in its power-up state with an empty buffer; the
// buffer reads as zero per entry until written, tracked by a valid bit each.
// A stall on the result side holds the result and stops input acceptance.
`default_nettype none

module char_lcd_init_and_string_writer_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // go [0], char_index [5:1], char_value [13:6]
    input  wire logic [0:0]  s_tuser,   // operation [0]
    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // bus_data [7:0], lcd_rs [8], lcd_enable [9],
                                        // enable_pulsed_low [10], ready_res [11]
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int         AW      = $clog2(BUFFER_DEPTH);
    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    // Input field split.
    logic       in_go;
    logic [4:0] in_index;
    logic [7:0] in_char;
    logic       in_fire;
    logic       tick_fire;
    logic       wr_fire;

    assign in_go     = s_tdata[0];
    assign in_index  = s_tdata[5:1];
    assign in_char   = s_tdata[13:6];
    assign s_tready  = !m_tvalid || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign tick_fire = in_fire && (s_tuser[0] == clcd_pkg::OP_TICK);
    assign wr_fire   = in_fire && (s_tuser[0] == clcd_pkg::OP_WRITE);

    // Configuration registers.
    logic [7:0] wait_ticks_reg;
    logic [4:0] last_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_ticks_reg <= clcd_pkg::POWER_UP_WAIT_RST;
            last_index_reg <= clcd_pkg::LAST_CHAR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == clcd_pkg::REG_POWER_UP_WAIT)
                wait_ticks_reg <= cfg_data;
            else if (cfg_index == clcd_pkg::REG_LAST_CHAR)
                last_index_reg <= cfg_data[4:0];
        end
    end

    // Controller state and pins.
    clcd_pkg::state_t state_reg, state_next;
    logic [7:0] step_reg, step_next;
    logic       ready_reg, ready_next;
    logic [7:0] data_reg, data_next;
    logic       rs_reg, rs_next;
    logic       en_reg, en_next;
    logic       pulsed_reg, pulsed_next;
    logic       out_valid_reg;

    // Buffered character for the current step, with write forwarding.
    logic [7:0] char_rd;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        ready_next  = ready_reg;
        data_next   = data_reg;
        rs_next     = rs_reg;
        en_next     = en_reg;
        pulsed_next = 1'b0;

        if (tick_fire)
        begin
            // Transition.
            case (state_reg)
                clcd_pkg::ST_INIT1:
                begin
                    state_next = clcd_pkg::ST_INIT2;
                    step_next  = 8'd0;
                end
                clcd_pkg::ST_INIT2:
                begin
                    if (step_reg >= wait_ticks_reg)
                        state_next = clcd_pkg::ST_INIT3;
                end
                clcd_pkg::ST_INIT3:
                begin
                    state_next  = clcd_pkg::ST_INIT4;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                end
                clcd_pkg::ST_INIT4:
                begin
                    state_next  = clcd_pkg::ST_INIT5;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                end
                clcd_pkg::ST_INIT5:
                begin
                    state_next  = clcd_pkg::ST_INIT6;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                end
                clcd_pkg::ST_INIT6:
                begin
                    state_next  = clcd_pkg::ST_WAIT_GO;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                end
                clcd_pkg::ST_WAIT_GO:
                begin
                    if (in_go)
                    begin
                        ready_next = 1'b0;
                        state_next = clcd_pkg::ST_CLEAR;
                    end
                end
                clcd_pkg::ST_CLEAR:
                begin
                    state_next  = clcd_pkg::ST_CURSOR;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                    step_next   = 8'd0;
                end
                clcd_pkg::ST_CURSOR:
                begin
                    state_next  = clcd_pkg::ST_CHAR;
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                end
                clcd_pkg::ST_CHAR:
                begin
                    en_next     = 1'b0;
                    pulsed_next = 1'b1;
                    if (step_reg < {3'b000, last_index_reg})
                    begin
                        state_next = clcd_pkg::ST_CURSOR;
                        step_next  = step_reg + 8'd1;
                    end
                    else
                        state_next = clcd_pkg::ST_WAIT_GO0;
                end
                clcd_pkg::ST_WAIT_GO0:
                begin
                    if (!in_go)
                        state_next = clcd_pkg::ST_WAIT_GO;
                end
                default:
                begin
                    state_next = clcd_pkg::ST_INIT1;
                end
            endcase

            // Action of the state just entered.
            case (state_next)
                clcd_pkg::ST_INIT1:
                begin
                    ready_next = 1'b0;
                end
                clcd_pkg::ST_INIT2:
                begin
                    step_next = step_next + 8'd1;
                end
                clcd_pkg::ST_INIT3:
                begin
                    rs_next   = 1'b0;
                    data_next = clcd_pkg::CMD_FUNCTION_SET;
                    en_next   = 1'b1;
                end
                clcd_pkg::ST_INIT4:
                begin
                    rs_next   = 1'b0;
                    data_next = clcd_pkg::CMD_ENTRY_MODE;
                    en_next   = 1'b1;
                end
                clcd_pkg::ST_INIT5:
                begin
                    rs_next   = 1'b0;
                    data_next = clcd_pkg::CMD_DISPLAY_ON;
                    en_next   = 1'b1;
                end
                clcd_pkg::ST_INIT6, clcd_pkg::ST_CLEAR:
                begin
                    rs_next   = 1'b0;
                    data_next = clcd_pkg::CMD_CLEAR;
                    en_next   = 1'b1;
                end
                clcd_pkg::ST_WAIT_GO:
                begin
                    ready_next = 1'b1;
                end
                clcd_pkg::ST_CURSOR:
                begin
                    // First line counts up from the line base, the rest wraps in 8 bits.
                    rs_next = 1'b0;
                    en_next = 1'b1;
                    if (step_next < clcd_pkg::LINE_LEN)
                        data_next = clcd_pkg::CMD_LINE1_BASE + step_next;
                    else
                        data_next = clcd_pkg::CMD_LINE2_BASE + step_next;
                end
                clcd_pkg::ST_CHAR:
                begin
                    rs_next   = 1'b1;
                    data_next = char_rd;
                    en_next   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // State, pins and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clcd_pkg::ST_POWERUP;
            step_reg      <= 8'd0;
            ready_reg     <= 1'b0;
            data_reg      <= 8'd0;
            rs_reg        <= 1'b0;
            en_reg        <= 1'b0;
            pulsed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg  <= state_next;
                step_reg   <= step_next;
                ready_reg  <= ready_next;
                data_reg   <= data_next;
                rs_reg     <= rs_next;
                en_reg     <= en_next;
                pulsed_reg <= pulsed_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Character buffer address: the step index folded into the buffer depth.
    // The step stays below 32 while characters are read, so one subtract suffices.
    logic [8:0]    step_wide;
    logic [8:0]    fold_wide;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    assign step_wide = {1'b0, step_next};
    assign fold_wide = (step_wide >= DEPTH_W) ? (step_wide - DEPTH_W) : step_wide;
    assign rd_addr   = fold_wide[AW-1:0];
    assign wr_addr   = AW'(in_index);
    assign wr_en     = wr_fire && (32'(in_index) < BUFFER_DEPTH);

    // Buffer memory, written by write items and read for the next step.
    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= in_char;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Valid bits: an entry never written reads as zero.
    logic [BUFFER_DEPTH-1:0] vld_reg;
    logic                    rd_vld_reg;
    logic                    hit_reg;
    logic [7:0]              hit_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
            hit_reg    <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Forward a write that landed at the same edge as the buffer read.
    always_ff @(posedge clk)
    begin
        hit_data_reg <= in_char;
    end

    always_comb
    begin
        if (hit_reg)
            char_rd = hit_data_reg;
        else if (rd_vld_reg)
            char_rd = rd_data_reg;
        else
            char_rd = 8'd0;
    end

    // Result port.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, ready_reg, pulsed_reg, en_reg, rs_reg, data_reg};

    // A stalled result blocks input acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the result was stalled");

    // Ready is only shown while waiting for a new string.
    assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (state_reg == clcd_pkg::ST_WAIT_GO))
        else $error("ready raised outside the wait-for-go state");

    // The character step never leaves the buffer index range.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == clcd_pkg::ST_CURSOR) || (state_reg == clcd_pkg::ST_CHAR))
            |-> (step_reg <= 8'd31))
        else $error("character step out of range");

    // A buffer write item does not move the controller.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire |=> $stable(state_reg))
        else $error("buffer write changed the controller state");

endmodule

`default_nettype wire
